// ----- design/mzdfs_pkg.sv -----
// Shared constants, types and codes for the grid maze depth-first path finder.
package mzdfs_pkg;

	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int CELL_W     = ROW_W + COL_W;
	localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
	localparam int DEPTH_W    = CELL_W + 1;
	localparam int DIR_W      = 3;
	localparam int STK_W      = CELL_W + DIR_W;

	// Command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_SOLVE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Neighbour order
	localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
	localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

	// Register indexes
	localparam logic [2:0] REG_ROWS  = 3'd0;
	localparam logic [2:0] REG_COLS  = 3'd1;
	localparam logic [2:0] REG_SROW  = 3'd2;
	localparam logic [2:0] REG_SCOL  = 3'd3;
	localparam logic [2:0] REG_GROW  = 3'd4;
	localparam logic [2:0] REG_GCOL  = 3'd5;

	// Request bundle from the sequencer to the storage block
	typedef struct packed {
		logic              wall_we;
		logic              wall_wd;
		logic [CELL_W-1:0] wall_addr;
		logic              vis_we;
		logic              vis_wd;
		logic [CELL_W-1:0] vis_addr;
		logic              stk_we;
		logic [STK_W-1:0]  stk_wd;
		logic [CELL_W-1:0] stk_addr;
	} store_req_t;

	typedef struct packed {
		logic             wall_rd;
		logic             vis_rd;
		logic [STK_W-1:0] stk_rd;
	} store_rsp_t;

endpackage

// ----- design/grid_maze_dfs_path_finder_unit.sv -----
// Grid maze path finder: stream command port, APB registers and the search sequencer.
// After reset the block sweeps its wall and visited maps before it takes a transfer. A
// wall write or an idle command answers straight from the idle state; a path read waits
// for a registered stack read. A solve first clears the visited map, then runs a
// depth-first search in which each neighbour that lies in the grid needs one memory read
// of the wall and visited maps, and each backtrack needs a stack read. One command is
// handled at a time; the next is taken once the result transfer has completed.
module grid_maze_dfs_path_finder_unit (
	input  logic        clk,
	input  logic        arst_n,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // cell_row_in, cell_col_in, wall_in, path_index, zero pad
	input  logic [1:0]  s_tuser,  // cmd
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // found, path_length, cell_row, cell_col, index_valid, pad
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mzdfs_pkg::*;

	localparam logic [3:0] ST_INIT   = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_CLR    = 4'd2;
	localparam logic [3:0] ST_SEVAL  = 4'd3;
	localparam logic [3:0] ST_EXPAND = 4'd4;
	localparam logic [3:0] ST_CHECK  = 4'd5;
	localparam logic [3:0] ST_POPW   = 4'd6;
	localparam logic [3:0] ST_GOALW  = 4'd7;
	localparam logic [3:0] ST_RDW    = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	logic [3:0]          state_q;
	logic [CELL_W-1:0]   sweep_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic                found_q;
	logic [CELL_W-1:0]   top_q;
	logic [DIR_W-1:0]    dir_q;
	logic [CELL_W-1:0]   nidx_q;
	logic                rd_ok_q;
	logic [6:0]          rows_q, cols_q;
	logic [5:0]          srow_q, scol_q, grow_q, gcol_q;
	logic                m_valid_q;
	logic [31:0]         m_data_q;

	logic [ROW_W:0]      eff_rows;
	logic [COL_W:0]      eff_cols;
	logic [CELL_W-1:0]   start_cell, goal_cell, nbr;
	logic                nbr_ok, start_in, acc, cfg_wr;
	logic [5:0]          in_row, in_col;
	logic                in_wall;
	logic [11:0]         in_pidx;
	logic [1:0]          in_cmd;
	store_req_t          req;
	store_rsp_t          rsp;

	assign in_row  = s_tdata[5:0];
	assign in_col  = s_tdata[11:6];
	assign in_wall = s_tdata[12];
	assign in_pidx = s_tdata[24:13];
	assign in_cmd  = s_tuser;

	assign s_tready = (state_q == ST_IDLE) && !m_valid_q;
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd64;
			cols_q <= 7'd64;
			srow_q <= 6'd0;
			scol_q <= 6'd1;
			grow_q <= 6'd63;
			gcol_q <= 6'd62;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_ROWS: rows_q <= pwdata[6:0];
				REG_COLS: cols_q <= pwdata[6:0];
				REG_SROW: srow_q <= pwdata[5:0];
				REG_SCOL: scol_q <= pwdata[5:0];
				REG_GROW: grow_q <= pwdata[5:0];
				REG_GCOL: gcol_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_ROWS: prdata = {25'd0, rows_q};
			REG_COLS: prdata = {25'd0, cols_q};
			REG_SROW: prdata = {26'd0, srow_q};
			REG_SCOL: prdata = {26'd0, scol_q};
			REG_GROW: prdata = {26'd0, grow_q};
			REG_GCOL: prdata = {26'd0, gcol_q};
			default:  prdata = '0;
		endcase
	end

	// Grid size clamped to storage
	assign eff_rows   = (rows_q > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_q;
	assign eff_cols   = (cols_q > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cols_q;
	assign start_cell = {srow_q, scol_q};
	assign goal_cell  = {grow_q, gcol_q};
	assign start_in   = ({1'b0, srow_q} < eff_rows) && ({1'b0, scol_q} < eff_cols);

	mzdfs_nbr u_nbr (
		.cur_cell (top_q),
		.dir      (dir_q),
		.eff_rows (eff_rows),
		.eff_cols (eff_cols),
		.nbr      (nbr),
		.ok       (nbr_ok)
	);

	mzdfs_store u_store (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	// Memory requests
	always_comb begin
		req = '0;
		case (state_q)
			ST_INIT: begin
				req.wall_we   = 1'b1;
				req.wall_addr = sweep_q;
				req.vis_we    = 1'b1;
				req.vis_addr  = sweep_q;
			end
			ST_IDLE: begin
				req.wall_we   = acc && (in_cmd == CMD_WRITE);
				req.wall_wd   = in_wall;
				req.wall_addr = {in_row, in_col};
				req.stk_addr  = in_pidx;
			end
			ST_CLR: begin
				req.vis_we    = 1'b1;
				req.vis_addr  = sweep_q;
				req.wall_addr = start_cell;
			end
			ST_SEVAL: begin
				req.vis_we    = !rsp.wall_rd && (start_cell != goal_cell);
				req.vis_wd    = 1'b1;
				req.vis_addr  = start_cell;
				req.stk_we    = !rsp.wall_rd && (start_cell == goal_cell);
				req.stk_wd    = {DIR_UP, start_cell};
				req.stk_addr  = '0;
			end
			ST_EXPAND: begin
				req.wall_addr = nbr;
				req.vis_addr  = nbr;
				req.stk_addr  = CELL_W'(depth_q - DEPTH_W'(2));
			end
			ST_CHECK: begin
				req.stk_we    = !rsp.wall_rd && !rsp.vis_rd &&
				                (depth_q < DEPTH_W'(CELL_COUNT));
				req.stk_wd    = {dir_q, top_q};
				req.stk_addr  = CELL_W'(depth_q - 1'b1);
				req.vis_we    = req.stk_we && (nidx_q != goal_cell);
				req.vis_wd    = 1'b1;
				req.vis_addr  = nidx_q;
			end
			ST_GOALW: begin
				req.stk_we    = 1'b1;
				req.stk_wd    = {DIR_UP, top_q};
				req.stk_addr  = CELL_W'(depth_q - 1'b1);
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			sweep_q   <= '0;
			depth_q   <= '0;
			found_q   <= 1'b0;
			top_q     <= '0;
			dir_q     <= '0;
			nidx_q    <= '0;
			rd_ok_q   <= 1'b0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						if (in_cmd == CMD_SOLVE) begin
							depth_q <= '0;
							found_q <= 1'b0;
							sweep_q <= '0;
							state_q <= ST_CLR;
						end else if (in_cmd == CMD_READ) begin
							rd_ok_q <= {1'b0, in_pidx} < depth_q;
							state_q <= ST_RDW;
						end else begin
							m_valid_q <= 1'b1;
							m_data_q  <= {18'd0, depth_q, found_q};
						end
					end
				end
				ST_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == '1) begin
						state_q <= start_in ? ST_SEVAL : ST_DONE;
					end
				end
				ST_SEVAL: begin
					if (rsp.wall_rd) begin
						state_q <= ST_DONE;
					end else if (start_cell == goal_cell) begin
						depth_q <= DEPTH_W'(1);
						found_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						depth_q <= DEPTH_W'(1);
						top_q   <= start_cell;
						dir_q   <= DIR_UP;
						state_q <= ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					if (dir_q == DIR_DONE) begin
						depth_q <= depth_q - 1'b1;
						state_q <= (depth_q == DEPTH_W'(1)) ? ST_DONE : ST_POPW;
					end else begin
						dir_q  <= dir_q + 1'b1;
						nidx_q <= nbr;
						if (nbr_ok) begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_POPW: begin
					top_q   <= rsp.stk_rd[CELL_W-1:0];
					dir_q   <= rsp.stk_rd[STK_W-1:CELL_W];
					state_q <= ST_EXPAND;
				end
				ST_CHECK: begin
					state_q <= ST_EXPAND;
					if (req.stk_we) begin
						top_q   <= nidx_q;
						dir_q   <= DIR_UP;
						depth_q <= depth_q + 1'b1;
						if (nidx_q == goal_cell) begin
							found_q <= 1'b1;
							state_q <= ST_GOALW;
						end
					end
				end
				ST_GOALW: state_q <= ST_DONE;
				ST_RDW: begin
					// row sits below column on the result bus
					m_valid_q <= 1'b1;
					m_data_q  <= {5'd0, rd_ok_q,
					              rd_ok_q ? {rsp.stk_rd[COL_W-1:0], rsp.stk_rd[CELL_W-1:COL_W]}
					                      : {CELL_W{1'b0}},
					              depth_q, found_q};
					state_q   <= ST_IDLE;
				end
				ST_DONE: begin
					m_valid_q <= 1'b1;
					m_data_q  <= {18'd0, depth_q, found_q};
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(CELL_COUNT))
		else $error("stack depth above cell count");
	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && found_q |-> depth_q != '0)
		else $error("found with empty path");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_valid_q && (state_q == ST_IDLE))
		else $error("command taken while busy");
	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> m_valid_q)
		else $error("solve ended without result");

endmodule

// ----- design/mzdfs_store.sv -----
// Wall map, visited map and search stack memories with registered reads.
module mzdfs_store (
	input  logic                  clk,
	input  mzdfs_pkg::store_req_t req,
	output mzdfs_pkg::store_rsp_t rsp
);
	import mzdfs_pkg::*;

	logic             wall_mem [CELL_COUNT];
	logic             vis_mem  [CELL_COUNT];
	logic [STK_W-1:0] stk_mem  [CELL_COUNT];

	// Wall map
	always_ff @(posedge clk) begin
		if (req.wall_we) begin
			wall_mem[req.wall_addr] <= req.wall_wd;
		end
		rsp.wall_rd <= wall_mem[req.wall_addr];
	end

	// Visited map
	always_ff @(posedge clk) begin
		if (req.vis_we) begin
			vis_mem[req.vis_addr] <= req.vis_wd;
		end
		rsp.vis_rd <= vis_mem[req.vis_addr];
	end

	// Search stack, which also holds the path after a successful solve
	always_ff @(posedge clk) begin
		if (req.stk_we) begin
			stk_mem[req.stk_addr] <= req.stk_wd;
		end
		rsp.stk_rd <= stk_mem[req.stk_addr];
	end

endmodule

// ----- design/mzdfs_nbr.sv -----
// Neighbour address unit: steps one cell in a direction and checks the grid bounds.
module mzdfs_nbr (
	input  logic [mzdfs_pkg::CELL_W-1:0] cur_cell,
	input  logic [mzdfs_pkg::DIR_W-1:0]  dir,
	input  logic [mzdfs_pkg::ROW_W:0]    eff_rows,
	input  logic [mzdfs_pkg::COL_W:0]    eff_cols,
	output logic [mzdfs_pkg::CELL_W-1:0] nbr,
	output logic                         ok
);
	import mzdfs_pkg::*;

	logic [ROW_W:0] r, nr;
	logic [COL_W:0] c, nc;
	logic           wrap;

	assign r = {1'b0, cur_cell[CELL_W-1:COL_W]};
	assign c = {1'b0, cur_cell[COL_W-1:0]};

	// One step; stepping below zero fails
	always_comb begin
		nr   = r;
		nc   = c;
		wrap = 1'b0;
		case (dir)
			DIR_UP: begin
				wrap = (r == '0);
				nr   = r - 1'b1;
			end
			DIR_DOWN:  nr = r + 1'b1;
			DIR_LEFT: begin
				wrap = (c == '0);
				nc   = c - 1'b1;
			end
			DIR_RIGHT: nc = c + 1'b1;
			default:   wrap = 1'b1;
		endcase
	end

	assign ok  = !wrap && (nr < eff_rows) && (nc < eff_cols);
	assign nbr = {nr[ROW_W-1:0], nc[COL_W-1:0]};

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the grid maze depth-first path finder: directed table and cases, then random phases.
`timescale 1ns / 1ps

module tb_top;
	import mzdfs_pkg::*;

	// Spare command code, handled like a write that stores nothing
	localparam logic [1:0] CMD_SPARE = 2'd3;

	// Result fields carried on m_tdata
	typedef struct packed {
		logic        found;
		logic [12:0] path_len;
		logic [5:0]  row;
		logic [5:0]  col;
		logic        idx_ok;
	} maze_res_t;

	// Directed stimulus row; typed rows carry their own expected result
	typedef struct {
		logic [1:0]  cmd;
		logic [5:0]  r;
		logic [5:0]  c;
		logic        w;
		logic [11:0] idx;
		bit          typed;
		maze_res_t   res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = CMD_WRITE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	grid_maze_dfs_path_finder_unit u_top (.*);

	// Shadow of the block's registers and storage
	int          cfg_val [6];
	bit          wall_bits [CELL_COUNT];
	bit          seen_bits [CELL_COUNT];
	int          path_cells [CELL_COUNT];
	int          try_dir [CELL_COUNT];
	int          path_depth;
	bit          path_found;

	maze_res_t   pending_res [$];
	int          n_errors = 0;
	int          n_results = 0;
	int          n_items = 0;
	int          n_solves = 0;
	int          n_hits = 0;

	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;
	bit          hold_req = 1'b0;
	int          rx_gap = 0;
	int          long_hold = 0;

	// Clock
	initial begin
		forever #10 clk = ~clk;
	end

	// Run limit
	initial begin
		#60_000_000;
		$display("FAIL grid_maze_dfs_path_finder_unit");
		$finish;
	end

	function automatic int eff_rows();
		return (cfg_val[REG_ROWS] > MAX_ROWS) ? MAX_ROWS : cfg_val[REG_ROWS];
	endfunction

	function automatic int eff_cols();
		return (cfg_val[REG_COLS] > MAX_COLS) ? MAX_COLS : cfg_val[REG_COLS];
	endfunction

	function automatic bit cell_free(int r, int c);
		if (r < 0 || c < 0 || r >= eff_rows() || c >= eff_cols())
			return 1'b0;
		return !wall_bits[r * MAX_COLS + c];
	endfunction

	// Depth-first search with an explicit stack, neighbours up, down, left, right
	function automatic void search_maze();
		int sr, sc, gr, gc, cur, d, nr, nc, nidx;
		sr = cfg_val[REG_SROW];
		sc = cfg_val[REG_SCOL];
		gr = cfg_val[REG_GROW];
		gc = cfg_val[REG_GCOL];
		foreach (seen_bits[i])
			seen_bits[i] = 1'b0;
		path_found = 1'b0;
		path_depth = 0;
		if (!cell_free(sr, sc))
			return;
		path_cells[0] = sr * MAX_COLS + sc;
		try_dir[0] = 0;
		path_depth = 1;
		if (sr == gr && sc == gc) begin
			path_found = 1'b1;
			return;
		end
		seen_bits[sr * MAX_COLS + sc] = 1'b1;
		while (path_depth > 0) begin
			cur = path_cells[path_depth - 1];
			d = try_dir[path_depth - 1];
			if (d >= 4) begin
				path_depth--;
				continue;
			end
			try_dir[path_depth - 1] = d + 1;
			nr = cur / MAX_COLS;
			nc = cur % MAX_COLS;
			case (d)
				0: nr--;
				1: nr++;
				2: nc--;
				default: nc++;
			endcase
			if (!cell_free(nr, nc))
				continue;
			nidx = nr * MAX_COLS + nc;
			if (seen_bits[nidx] || path_depth >= CELL_COUNT)
				continue;
			path_cells[path_depth] = nidx;
			try_dir[path_depth] = 0;
			path_depth++;
			if (nr == gr && nc == gc) begin
				path_found = 1'b1;
				return;
			end
			seen_bits[nidx] = 1'b1;
		end
		path_depth = 0;
	endfunction

	// Apply one command to the shadow state and return the result it produces
	function automatic maze_res_t predict_cmd(logic [1:0] cmd, logic [5:0] r, logic [5:0] c,
			logic w, logic [11:0] idx);
		maze_res_t res;
		res.row = '0;
		res.col = '0;
		res.idx_ok = 1'b0;
		case (cmd)
			CMD_WRITE: wall_bits[r * MAX_COLS + c] = w;
			CMD_SOLVE: begin
				search_maze();
				n_solves++;
				if (path_found)
					n_hits++;
			end
			CMD_READ: begin
				if (idx < path_depth) begin
					res.row = 6'(path_cells[idx] / MAX_COLS);
					res.col = 6'(path_cells[idx] % MAX_COLS);
					res.idx_ok = 1'b1;
				end
			end
			default: ;
		endcase
		res.found = path_found;
		res.path_len = 13'(path_depth);
		return res;
	endfunction

	// APB write: setup then access; the register takes the value at the access edge
	task automatic reg_write(logic [2:0] idx, int val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_val[idx] = val & ((idx <= REG_COLS) ? 'h7F : 'h3F);
	endtask

	task automatic set_maze(int rows, int cols, int sr, int sc, int gr, int gc);
		reg_write(REG_ROWS, rows);
		reg_write(REG_COLS, cols);
		reg_write(REG_SROW, sr);
		reg_write(REG_SCOL, sc);
		reg_write(REG_GROW, gr);
		reg_write(REG_GCOL, gc);
	endtask

	// Offer one command until accepted, then queue what it should return
	task automatic send_cmd(logic [1:0] cmd, logic [5:0] r, logic [5:0] c, logic w,
			logic [11:0] idx, bit typed = 1'b0, maze_res_t typed_res = '{default: 0});
		maze_res_t res;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {7'd0, idx, w, c, r};
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
		res = predict_cmd(cmd, r, c, w, idx);
		pending_res = {pending_res, (typed ? typed_res : res)};
		n_items++;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9))
				@(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	// Result side: random back-pressure and field-by-field check
	always @(posedge clk) begin
		maze_res_t want;
		maze_res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.found = m_tdata[0];
			got.path_len = m_tdata[13:1];
			got.row = m_tdata[19:14];
			got.col = m_tdata[25:20];
			got.idx_ok = m_tdata[26];
			n_results++;
			if (pending_res.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("ERROR: result with nothing expected, tdata %h", m_tdata);
			end else begin
				want = pending_res.pop_front();
				if (got != want) begin
					n_errors++;
					if (n_errors <= 10)
						$display("ERROR: result %0d exp f%0d len%0d (%0d,%0d) v%0d %s",
							n_results, want.found, want.path_len, want.row, want.col,
							want.idx_ok, $sformatf("got f%0d len%0d (%0d,%0d) v%0d",
							got.found, got.path_len, got.row, got.col, got.idx_ok));
				end
			end
		end
		if (long_hold > 0) begin
			long_hold--;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			long_hold = 300;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
			rx_gap = $urandom_range(1, 9) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// One random phase: walls, solve, reads along the path, some noise
	task automatic random_phase(int n);
		int k;
		int er;
		int ec;
		logic [5:0]  rr;
		logic [5:0]  cc;
		logic        ww;
		logic [11:0] ii;
		er = (eff_rows() == 0) ? 1 : eff_rows();
		ec = (eff_cols() == 0) ? 1 : eff_cols();
		for (k = 0; k < n; k++) begin
			rr = 6'($urandom);
			cc = 6'($urandom);
			ww = 1'($urandom);
			ii = 12'($urandom);
			case ($urandom_range(0, 9))
				0, 1, 2: send_cmd(CMD_WRITE, 6'($urandom_range(0, er - 1)),
					6'($urandom_range(0, ec - 1)), $urandom_range(0, 2) == 0, ii);
				3: send_cmd(CMD_SOLVE, rr, cc, ww, ii);
				4, 5, 6: send_cmd(CMD_READ, rr, cc, ww, (path_depth > 0) ?
					12'($urandom_range(0, path_depth - 1)) : 12'($urandom_range(0, 3)));
				7: send_cmd(CMD_READ, rr, cc, ww, ii);
				8: send_cmd(CMD_SPARE, rr, cc, ww, ii);
				default: send_cmd(CMD_WRITE, rr, cc, ww, ii);
			endcase
		end
		send_cmd(CMD_SOLVE, 6'd0, 6'd0, 1'b0, 12'd0);
		send_cmd(CMD_READ, 6'd0, 6'd0, 1'b0, (path_depth > 0) ? 12'(path_depth - 1) : 12'd0);
		drain();
	endtask

	// Directed table on the power-up maze
	stim_row_t stim_rows [] = '{
		'{CMD_READ,  6'd0,  6'd0,  1'b0, 12'd0,    1'b1, '{0, 0, 0, 0, 0}},
		'{CMD_SPARE, 6'd63, 6'd63, 1'b1, 12'hFFF,  1'b1, '{0, 0, 0, 0, 0}},
		'{CMD_WRITE, 6'd63, 6'd63, 1'b1, 12'hFFF,  1'b1, '{0, 0, 0, 0, 0}},
		'{CMD_WRITE, 6'd0,  6'd0,  1'b1, 12'd0,    1'b1, '{0, 0, 0, 0, 0}},
		'{CMD_WRITE, 6'd63, 6'd63, 1'b0, 12'd0,    1'b1, '{0, 0, 0, 0, 0}},
		'{CMD_SOLVE, 6'd0,  6'd0,  1'b0, 12'd0,    1'b0, '{0, 0, 0, 0, 0}},
		'{CMD_READ,  6'd0,  6'd0,  1'b0, 12'd0,    1'b0, '{0, 0, 0, 0, 0}},
		'{CMD_READ,  6'd0,  6'd0,  1'b0, 12'd1,    1'b0, '{0, 0, 0, 0, 0}},
		'{CMD_READ,  6'd0,  6'd0,  1'b0, 12'd2047, 1'b0, '{0, 0, 0, 0, 0}},
		'{CMD_READ,  6'd0,  6'd0,  1'b0, 12'hFFF,  1'b0, '{0, 0, 0, 0, 0}},
		'{CMD_WRITE, 6'd0,  6'd1,  1'b1, 12'd0,    1'b0, '{0, 0, 0, 0, 0}},
		'{CMD_READ,  6'd0,  6'd0,  1'b0, 12'd0,    1'b0, '{0, 0, 0, 0, 0}},
		'{CMD_SOLVE, 6'd0,  6'd0,  1'b0, 12'd0,    1'b1, '{0, 0, 0, 0, 0}},
		'{CMD_READ,  6'd0,  6'd0,  1'b0, 12'd0,    1'b1, '{0, 0, 0, 0, 0}}
	};

	initial begin
		int i;
		cfg_val = '{64, 64, 0, 1, 63, 62};
		foreach (wall_bits[i])
			wall_bits[i] = 1'b0;
		path_depth = 0;
		path_found = 1'b0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i])
			send_cmd(stim_rows[i].cmd, stim_rows[i].r, stim_rows[i].c, stim_rows[i].w,
				stim_rows[i].idx, stim_rows[i].typed, stim_rows[i].res);
		drain();

		// Start equal to goal, then start on a wall, goal on a wall, empty grid
		set_maze(4, 4, 2, 2, 2, 2);
		send_cmd(CMD_SOLVE, 0, 0, 0, 0);
		send_cmd(CMD_READ, 0, 0, 0, 0);
		send_cmd(CMD_WRITE, 2, 2, 1, 0);
		send_cmd(CMD_SOLVE, 0, 0, 0, 0);
		send_cmd(CMD_WRITE, 2, 2, 0, 0);
		send_cmd(CMD_WRITE, 3, 3, 1, 0);
		drain();
		set_maze(4, 4, 0, 0, 3, 3);
		send_cmd(CMD_SOLVE, 0, 0, 0, 0);
		drain();
		set_maze(0, 0, 0, 0, 0, 0);
		send_cmd(CMD_SOLVE, 0, 0, 0, 0);
		drain();

		// Long hold-off on the result side while commands keep coming
		hold_req = 1'b1;
		set_maze(127, 127, 63, 63, 0, 0);
		send_cmd(CMD_WRITE, 10, 10, 1, 0);
		send_cmd(CMD_READ, 0, 0, 0, 5);
		send_cmd(CMD_READ, 0, 0, 0, 0);
		drain();

		// Random phases on small grids, goal sometimes off the grid, then one on the full grid
		for (i = 0; i < 7; i++) begin
			if (i == 6) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
			end
			set_maze($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 7),
				$urandom_range(0, 7), $urandom_range(0, 8), $urandom_range(0, 8));
			random_phase(11);
		end
		set_maze(64, 64, 0, 0, 63, 63);
		random_phase(6);

		repeat (20)
			@(posedge clk);
		$display("Covered %0d commands and %0d results: %0d searches, %0d reached the goal.",
			n_items, n_results, n_solves, n_hits);
		if (n_errors == 0 && pending_res.size() == 0)
			$display("PASS grid_maze_dfs_path_finder_unit");
		else
			$display("FAIL grid_maze_dfs_path_finder_unit");
		$finish;
	end

endmodule
